@@ rtl/krt_pkg.sv @@
`default_nettype none
package krt_pkg;

	localparam int SLOTS = 64;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam int KEY_W = 27;
	localparam int AGE_W = 7;
	localparam int OP_W  = 2;
	localparam int ST_W  = 3;
	localparam int OIDX_W = 6;
	localparam int OCNT_W = 7;

	localparam logic [AGE_W-1:0] AGE_LIMIT   = 7'd100;
	localparam logic [AGE_W-1:0] YOUNG_BELOW = 7'd18;
	localparam logic [AGE_W-1:0] MIDDLE_TOP  = 7'd35;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 3'd0,
		ST_FULL = 3'd1,
		ST_DUP  = 3'd2,
		ST_MISS = 3'd3,
		ST_AGE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		GRP_YOUNG  = 2'd0,
		GRP_MIDDLE = 2'd1,
		GRP_OLD    = 2'd2
	} grp_t;

	// Search token that walks the row of slots, one slot per cycle.
	typedef struct packed {
		logic             active;
		logic             free_hit;
		logic [IDX_W-1:0] free_idx;
		logic             key_hit;
		logic [IDX_W-1:0] hit_idx;
		logic [AGE_W-1:0] hit_age;
	} krt_token_t;

	// Write broadcast to every slot; only the addressed slot takes it.
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} krt_commit_t;

	function automatic grp_t age_group(input logic [AGE_W-1:0] age);
		grp_t g;
		if (age < YOUNG_BELOW) begin
			g = GRP_YOUNG;
		end else if (age > MIDDLE_TOP) begin
			g = GRP_OLD;
		end else begin
			g = GRP_MIDDLE;
		end
		return g;
	endfunction

	function automatic logic [OCNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
		logic [OCNT_W-1:0] r;
		if (32'(c) > 127) begin
			r = 7'd127;
		end else begin
			r = OCNT_W'(c);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/krt_req_if.sv @@
`default_nettype none
interface krt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [26:0] record_key;
	logic [6:0]  record_age;

	modport source (output valid, output opcode, output record_key, output record_age,
		input ready);
	modport sink (input valid, input opcode, input record_key, input record_age,
		output ready);
endinterface
`default_nettype wire

@@ rtl/krt_rsp_if.sv @@
`default_nettype none
interface krt_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       found;
	logic [5:0] slot_index;
	logic [6:0] found_age;
	logic [6:0] count_young;
	logic [6:0] count_middle;
	logic [6:0] count_old;

	modport source (output valid, output status, output found, output slot_index,
		output found_age, output count_young, output count_middle, output count_old,
		input ready);
	modport sink (input valid, input status, input found, input slot_index,
		input found_age, input count_young, input count_middle, input count_old,
		output ready);
endinterface
`default_nettype wire

@@ rtl/krt_cell.sv @@
`default_nettype none
module krt_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [krt_pkg::IDX_W-1:0] slot_id,
	input  wire logic [krt_pkg::KEY_W-1:0] key,
	input  wire krt_pkg::krt_token_t       tok_in,
	input  wire krt_pkg::krt_commit_t      commit,
	output krt_pkg::krt_token_t            tok_out
);
	import krt_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [AGE_W-1:0] age_q;
	krt_token_t       tok_nxt;
	krt_token_t       tok_q;
	logic             addressed;

	assign addressed = (commit.idx == slot_id);

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.active) begin
			// The first free slot and the first matching in-use slot win.
			if (!tok_in.free_hit && !valid_q) begin
				tok_nxt.free_hit = 1'b1;
				tok_nxt.free_idx = slot_id;
			end
			if (!tok_in.key_hit && valid_q && (key_q == key)) begin
				tok_nxt.key_hit = 1'b1;
				tok_nxt.hit_idx = slot_id;
				tok_nxt.hit_age = age_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (addressed && commit.set) begin
			valid_q <= 1'b1;
		end else if (addressed && commit.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (addressed && commit.set) begin
			key_q <= commit.key;
			age_q <= commit.age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

@@ rtl/krt_ctrl.sv @@
`default_nettype none
module krt_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	krt_req_if.sink                        req,
	krt_rsp_if.source                      rsp,
	output krt_pkg::krt_token_t            tok_first,
	input  wire krt_pkg::krt_token_t       tok_last,
	output logic [krt_pkg::KEY_W-1:0]      key,
	output krt_pkg::krt_commit_t           commit
);
	import krt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t            state_q;
	logic              start_q;
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [AGE_W-1:0]  age_q;
	krt_token_t        res_q;
	logic [CNT_W-1:0]  young_q;
	logic [CNT_W-1:0]  middle_q;
	logic [CNT_W-1:0]  old_q;

	logic              rsp_valid_q;
	logic [ST_W-1:0]   status_q;
	logic              found_q;
	logic [IDX_W-1:0]  idx_q;
	logic [AGE_W-1:0]  fage_q;

	logic              req_fire;
	logic              fire;
	krt_commit_t       cmt;
	status_t           d_status;
	logic              d_found;
	logic [IDX_W-1:0]  d_idx;
	logic [AGE_W-1:0]  d_fage;
	grp_t              inc_grp;
	grp_t              dec_grp;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	// The result leaves once the output register is empty or being emptied.
	assign fire      = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	assign key = key_q;

	always_comb begin
		tok_first          = '0;
		tok_first.active   = start_q;
	end

	always_comb begin
		cmt      = '0;
		d_status = ST_OK;
		d_found  = 1'b0;
		d_idx    = '0;
		d_fage   = '0;
		unique case (op_q)
			OP_INSERT: begin
				if (!res_q.free_hit) begin
					d_status = ST_FULL;
				end else if (age_q > AGE_LIMIT) begin
					d_status = ST_AGE;
				end else if (res_q.key_hit) begin
					d_status = ST_DUP;
					d_found  = 1'b1;
					d_idx    = res_q.hit_idx;
				end else begin
					cmt.set = 1'b1;
					cmt.idx = res_q.free_idx;
					cmt.key = key_q;
					cmt.age = age_q;
					d_idx   = res_q.free_idx;
				end
			end
			OP_DELETE: begin
				if (!res_q.key_hit) begin
					d_status = ST_MISS;
				end else begin
					cmt.clr = 1'b1;
					cmt.idx = res_q.hit_idx;
					d_found = 1'b1;
					d_idx   = res_q.hit_idx;
				end
			end
			OP_LOOKUP: begin
				if (!res_q.key_hit) begin
					d_status = ST_MISS;
				end else begin
					d_found = 1'b1;
					d_idx   = res_q.hit_idx;
					d_fage  = res_q.hit_age;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		commit = cmt;
		if (!fire) begin
			commit.set = 1'b0;
			commit.clr = 1'b0;
		end
	end

	assign inc_grp = age_group(age_q);
	assign dec_grp = age_group(res_q.hit_age);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= req_fire;
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tok_last.active) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= req.opcode;
			key_q <= req.record_key;
			age_q <= req.record_age;
		end
		if ((state_q == S_SCAN) && tok_last.active) begin
			res_q <= tok_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			young_q  <= '0;
			middle_q <= '0;
			old_q    <= '0;
		end else if (commit.set) begin
			unique case (inc_grp)
				GRP_YOUNG:  young_q  <= young_q + CNT_W'(1);
				GRP_MIDDLE: middle_q <= middle_q + CNT_W'(1);
				GRP_OLD:    old_q    <= old_q + CNT_W'(1);
				default: begin
				end
			endcase
		end else if (commit.clr) begin
			unique case (dec_grp)
				GRP_YOUNG:  young_q  <= young_q - CNT_W'(1);
				GRP_MIDDLE: middle_q <= middle_q - CNT_W'(1);
				GRP_OLD:    old_q    <= old_q - CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= d_status;
			found_q  <= d_found;
			idx_q    <= d_idx;
			fage_q   <= d_fage;
		end
	end

	// The counts are sampled after the table update of the same request.
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.found        = found_q;
	assign rsp.slot_index   = OIDX_W'(idx_q);
	assign rsp.found_age    = fage_q;
	assign rsp.count_young  = sat_count(young_q);
	assign rsp.count_middle = sat_count(middle_q);
	assign rsp.count_old    = sat_count(old_q);

`ifndef SYNTHESIS
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(young_q) + 32'(middle_q) + 32'(old_q)) <= SLOTS)
		else $error("group counts exceed the number of slots");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_last.active |-> (state_q == S_SCAN))
		else $error("search token left the row outside a scan");

	a_start_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (start_q && (state_q == S_SCAN)))
		else $error("accepted request did not launch a scan");

	a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(commit.set || commit.clr) |=> rsp_valid_q)
		else $error("table update without a response");
`endif

endmodule
`default_nettype wire

@@ rtl/keyed_record_table.sv @@
// keyed_record_table: a table of SLOTS slots, each holding a key and an age.
// The req channel takes one request (opcode, record_key, record_age): insert
// into the lowest free slot, delete a matching key, or look a key up. The rsp
// channel returns one response per request with status, found, slot_index,
// found_age and the in-use counts of the three age groups after the request.
// Requests are taken one at a time. A search token walks the row of slot
// cells, one cell per clock; the controller registers the token leaving the
// row and then loads the response; a new request is taken only after the
// previous one has loaded its response and the controller is idle. The table
// update happens in the cycle the response is loaded.
// The output register holds a response until rsp.ready is seen; the next
// request is taken meanwhile and scans, but waits before its update while a
// response is still pending. Asynchronous reset (arst_n low) frees every
// slot, zeroes the counts and drops any request in flight; keys and ages of
// free slots are never read.
`default_nettype none
module keyed_record_table (
	input  wire logic clk,
	input  wire logic arst_n,
	krt_req_if.sink   req,
	krt_rsp_if.source rsp
);
	import krt_pkg::*;

	krt_token_t       tok [SLOTS+1];
	logic [KEY_W-1:0] key;
	krt_commit_t      commit;

	krt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.tok_first (tok[0]),
		.tok_last  (tok[SLOTS]),
		.key       (key),
		.commit    (commit)
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		krt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.slot_id (IDX_W'(i)),
			.key     (key),
			.tok_in  (tok[i]),
			.commit  (commit),
			.tok_out (tok[i+1])
		);
	end

endmodule
`default_nettype wire
